// ----- rtl/icf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_pkg
// Shared types, constants and helpers for the complementary angle filter.
// ----------------------------------------------------------------------------
package icf_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  localparam int TAB_FRAC   = 24;
  localparam int TAB_IDX_W  = 5;
  localparam int PRE_SHIFT  = 14;
  localparam int CZ_W       = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int PROD_W     = 50;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_HIGH = 2'd3;

  localparam logic [15:0] GYRO_GAIN_RST      = 16'd639;
  localparam logic [16:0] BLEND_WEIGHT_RST   = 17'd64225;
  localparam logic [16:0] MAGNITUDE_LOW_RST  = 17'd8192;
  localparam logic [16:0] MAGNITUDE_HIGH_RST = 17'd32768;

  localparam logic [16:0]              WEIGHT_ONE = 17'd65536;
  localparam logic signed [PROD_W-1:0] BLEND_RND  = 50'sd32768;
  localparam logic signed [CZ_W-1:0]   Z_QUARTER  = 34'sd1509949440;

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               used;
  } icf_item_t;

  // arctangent of 2^-i in 2^-24 degree
  function automatic logic [29:0] icf_atan(input logic [TAB_IDX_W-1:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] icf_sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic [16:0] icf_abs16(input logic signed [15:0] a);
    logic signed [16:0] e;
    logic [16:0]        r;
    e = 17'(a);
    r = e[16] ? 17'(-e) : 17'(e);
    return r;
  endfunction

endpackage

// ----- rtl/icf_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_fifo
// Short sample queue between the classify front and the compute back.
// ----------------------------------------------------------------------------
module icf_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  icf_pkg::icf_item_t wr_data,
  output logic              full,
  input  logic              pop,
  output icf_pkg::icf_item_t rd_data,
  output logic              empty
);
  import icf_pkg::*;

  icf_item_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]      count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/icf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_front
// Input stage: takes a sample, sums absolute accelerations and flags blend.
// ----------------------------------------------------------------------------
module icf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic signed [15:0] in_rate_z,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [16:0]        mag_low,
  input  logic [16:0]        mag_high,
  output logic               push,
  output icf_pkg::icf_item_t item,
  input  logic               q_full
);
  import icf_pkg::*;

  logic       hold_valid_r, hold_valid_nxt;
  icf_item_t  hold_r, hold_nxt;
  logic       accept;
  logic [16:0] mag;

  assign in_stall = hold_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = hold_valid_r && !q_full;
  assign item     = hold_r;

  always_comb begin
    mag = 17'(icf_abs16(in_accel_x) + icf_abs16(in_accel_y) + icf_abs16(in_accel_z));
    hold_nxt         = hold_r;
    hold_valid_nxt   = hold_valid_r;
    if (accept) begin
      hold_nxt.rate_x  = in_rate_x;
      hold_nxt.rate_y  = in_rate_y;
      hold_nxt.rate_z  = in_rate_z;
      hold_nxt.accel_x = in_accel_x;
      hold_nxt.accel_y = in_accel_y;
      hold_nxt.accel_z = in_accel_z;
      hold_nxt.used    = (mag > mag_low) && (mag < mag_high);
      hold_valid_nxt   = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

// ----- rtl/icf_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_cordic
// Iterative vectoring CORDIC, atan2(y, x) in degrees, one step per cycle.
// ----------------------------------------------------------------------------
module icf_cordic #(
  parameter int CORDIC_STEPS    = icf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = icf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [15:0]                    y_in,
  input  logic signed [15:0]                    x_in,
  output logic                                  done,
  output logic signed [ANGLE_FRAC_BITS+8:0]     result
);
  import icf_pkg::*;

  localparam int ACC_W = ANGLE_FRAC_BITS + 9;
  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
  localparam int ZSH   = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [CZ_W-1:0] ZRND = CZ_W'(1) <<< (ZSH - 1);

  logic                    run_r, run_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [CZ_W-1:0]  x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [ACC_W-1:0] res_r, res_nxt;
  logic signed [CZ_W-1:0]  xs, ys, dx, dy, tab, zr;

  assign done   = done_r;
  assign result = res_r;

  always_comb begin
    xs  = CZ_W'(x_in) <<< PRE_SHIFT;
    ys  = CZ_W'(y_in) <<< PRE_SHIFT;
    dx  = y_r >>> cnt_r;
    dy  = x_r >>> cnt_r;
    tab = $signed({{(CZ_W-30){1'b0}}, icf_atan(TAB_IDX_W'(cnt_r))});
    zr  = (z_r + ZRND) >>> ZSH;
    run_nxt  = run_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    res_nxt  = res_r;
    if (start) begin
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      if ((x_in == '0) && (y_in == '0)) begin
        res_nxt  = '0;
        done_nxt = 1'b1;
        run_nxt  = 1'b0;
      end else begin
        run_nxt = 1'b1;
        if (!x_in[15]) begin
          x_nxt = xs;
          y_nxt = ys;
          z_nxt = '0;
        end else if (!y_in[15]) begin
          x_nxt = ys;
          y_nxt = -xs;
          z_nxt = Z_QUARTER;
        end else begin
          x_nxt = -ys;
          y_nxt = xs;
          z_nxt = -Z_QUARTER;
        end
      end
    end else if (run_r) begin
      if (cnt_r == CNT_W'(CORDIC_STEPS)) begin
        res_nxt  = ACC_W'(zr);
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (!y_r[CZ_W-1]) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + tab;
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - tab;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    res_r <= res_nxt;
  end

endmodule

// ----- rtl/icf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_back
// Compute sequencer: gyro integration, accel blend and result register.
// ----------------------------------------------------------------------------
module icf_back #(
  parameter int CORDIC_STEPS    = icf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = icf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        gyro_gain,
  input  logic [16:0]        blend_weight,
  input  logic               q_empty,
  input  icf_pkg::icf_item_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_roll_angle,
  output logic signed [31:0] out_pitch_angle,
  output logic signed [31:0] out_yaw_angle,
  output logic               out_accel_used
);
  import icf_pkg::*;

  localparam int ACC_W = ANGLE_FRAC_BITS + 9;

  typedef enum logic [3:0] {
    S_IDLE, S_GX, S_GY, S_GZ, S_GW, S_WAIT,
    S_B1, S_B2, S_B3, S_B4, S_B5, S_OUT
  } state_t;

  state_t                    state_r, state_nxt;
  icf_item_t                 item_r, item_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt, sum_r, sum_nxt;
  logic signed [31:0]        pitch_r, pitch_nxt, roll_r, roll_nxt, yaw_r, yaw_nxt;
  logic                      ov_r, ov_nxt;
  logic signed [31:0]        o_roll_r, o_roll_nxt, o_pitch_r, o_pitch_nxt;
  logic signed [31:0]        o_yaw_r, o_yaw_nxt;
  logic                      o_used_r, o_used_nxt;

  logic signed [31:0]        mul_a;
  logic signed [17:0]        mul_b, gain_s, w_s, wc_s;
  logic [16:0]               w;
  logic signed [24:0]        inc;
  logic signed [PROD_W-1:0]  bsum;
  logic signed [31:0]        bres;
  logic                      cstart, p_done, r_done;
  logic signed [ACC_W-1:0]   p_acc, r_acc;

  assign q_pop           = (state_r == S_IDLE) && !q_empty;
  assign cstart          = q_pop && q_data.used;
  assign out_valid       = ov_r;
  assign out_roll_angle  = o_roll_r;
  assign out_pitch_angle = o_pitch_r;
  assign out_yaw_angle   = o_yaw_r;
  assign out_accel_used  = o_used_r;

  icf_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic_pitch (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cstart),
    .y_in   (q_data.accel_y),
    .x_in   (q_data.accel_z),
    .done   (p_done),
    .result (p_acc)
  );

  icf_cordic #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cstart),
    .y_in   (q_data.accel_x),
    .x_in   (q_data.accel_z),
    .done   (r_done),
    .result (r_acc)
  );

  always_comb begin
    w      = (blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight;
    gain_s = $signed({2'b00, gyro_gain});
    w_s    = $signed({1'b0, w});
    wc_s   = $signed({1'b0, 17'(WEIGHT_ONE - w)});
    inc    = $signed(prod_r[32:8]);
    bsum   = sum_r + prod_r + BLEND_RND;
    bres   = icf_sat32($signed(bsum[PROD_W-1:16]));

    mul_a = 32'(item_r.rate_x);
    mul_b = gain_s;
    unique case (state_r)
      S_GY:    mul_a = 32'(item_r.rate_y);
      S_GZ:    mul_a = 32'(item_r.rate_z);
      S_B1: begin
        mul_a = pitch_r;
        mul_b = w_s;
      end
      S_B2: begin
        mul_a = 32'(p_acc);
        mul_b = wc_s;
      end
      S_B3: begin
        mul_a = roll_r;
        mul_b = w_s;
      end
      S_B4: begin
        mul_a = 32'(r_acc);
        mul_b = wc_s;
      end
      default: begin
        mul_a = 32'(item_r.rate_x);
        mul_b = gain_s;
      end
    endcase
    prod_nxt = mul_a * mul_b;

    state_nxt   = state_r;
    item_nxt    = item_r;
    sum_nxt     = sum_r;
    pitch_nxt   = pitch_r;
    roll_nxt    = roll_r;
    yaw_nxt     = yaw_r;
    ov_nxt      = ov_r && out_stall;
    o_roll_nxt  = o_roll_r;
    o_pitch_nxt = o_pitch_r;
    o_yaw_nxt   = o_yaw_r;
    o_used_nxt  = o_used_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          item_nxt  = q_data;
          state_nxt = S_GX;
        end
      end
      S_GX: state_nxt = S_GY;
      S_GY: begin
        pitch_nxt = icf_sat32(34'(pitch_r) + 34'(inc));
        state_nxt = S_GZ;
      end
      S_GZ: begin
        roll_nxt  = icf_sat32(34'(roll_r) - 34'(inc));
        state_nxt = S_GW;
      end
      S_GW: begin
        yaw_nxt   = icf_sat32(34'(yaw_r) - 34'(inc));
        state_nxt = item_r.used ? S_WAIT : S_OUT;
      end
      S_WAIT: begin
        if (p_done && r_done) begin
          state_nxt = S_B1;
        end
      end
      S_B1: state_nxt = S_B2;
      S_B2: begin
        sum_nxt   = prod_r;
        state_nxt = S_B3;
      end
      S_B3: begin
        pitch_nxt = bres;
        state_nxt = S_B4;
      end
      S_B4: begin
        sum_nxt   = prod_r;
        state_nxt = S_B5;
      end
      S_B5: begin
        roll_nxt  = bres;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt      = 1'b1;
          o_roll_nxt  = roll_r;
          o_pitch_nxt = pitch_r;
          o_yaw_nxt   = yaw_r;
          o_used_nxt  = item_r.used;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pitch_r <= '0;
      roll_r  <= '0;
      yaw_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
      yaw_r   <= yaw_nxt;
      ov_r    <= ov_nxt;
    end
    item_r    <= item_nxt;
    prod_r    <= prod_nxt;
    sum_r     <= sum_nxt;
    o_roll_r  <= o_roll_nxt;
    o_pitch_r <= o_pitch_nxt;
    o_yaw_r   <= o_yaw_nxt;
    o_used_r  <= o_used_nxt;
  end

endmodule

// ----- rtl/imu_complementary_filter.sv -----
`timescale 1ns / 1ps
// Processing: the back end handles one sample at a time; a sample with accel
//   blend also waits for the iterative CORDIC, and the shared multiplier in
//   the back end serves gyro integration and blend in turn. The front end and
//   the queue take new samples while the back end is busy, until the queue
//   fills.
// Reset: synchronous; angles clear to zero, registers load their defaults.
// ----------------------------------------------------------------------------
// imu_complementary_filter
// Gyro integration with accelerometer tilt correction for roll/pitch/yaw.
// ----------------------------------------------------------------------------
module imu_complementary_filter #(
  parameter int CORDIC_STEPS    = icf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = icf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [icf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               in_rate_x,
  input  logic signed [15:0]               in_rate_y,
  input  logic signed [15:0]               in_rate_z,
  input  logic signed [15:0]               in_accel_x,
  input  logic signed [15:0]               in_accel_y,
  input  logic signed [15:0]               in_accel_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               out_roll_angle,
  output logic signed [31:0]               out_pitch_angle,
  output logic signed [31:0]               out_yaw_angle,
  output logic                             out_accel_used
);
  import icf_pkg::*;

  logic [15:0] gain_r, gain_nxt;
  logic [16:0] weight_r, weight_nxt;
  logic [16:0] mlow_r, mlow_nxt;
  logic [16:0] mhigh_r, mhigh_nxt;

  logic      push, q_full, q_empty, q_pop;
  icf_item_t f_item, q_item;

  always_comb begin
    gain_nxt   = gain_r;
    weight_nxt = weight_r;
    mlow_nxt   = mlow_r;
    mhigh_nxt  = mhigh_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_GYRO_GAIN:      gain_nxt   = cfg_data[15:0];
        REG_BLEND_WEIGHT:   weight_nxt = cfg_data;
        REG_MAGNITUDE_LOW:  mlow_nxt   = cfg_data;
        REG_MAGNITUDE_HIGH: mhigh_nxt  = cfg_data;
        default:            gain_nxt   = gain_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GYRO_GAIN_RST;
      weight_r <= BLEND_WEIGHT_RST;
      mlow_r   <= MAGNITUDE_LOW_RST;
      mhigh_r  <= MAGNITUDE_HIGH_RST;
    end else begin
      gain_r   <= gain_nxt;
      weight_r <= weight_nxt;
      mlow_r   <= mlow_nxt;
      mhigh_r  <= mhigh_nxt;
    end
  end

  icf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rate_x  (in_rate_x),
    .in_rate_y  (in_rate_y),
    .in_rate_z  (in_rate_z),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .mag_low    (mlow_r),
    .mag_high   (mhigh_r),
    .push       (push),
    .item       (f_item),
    .q_full     (q_full)
  );

  icf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (f_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  icf_back #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .gyro_gain       (gain_r),
    .blend_weight    (weight_r),
    .q_empty         (q_empty),
    .q_data          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle),
    .out_accel_used  (out_accel_used)
  );

endmodule

// ----- verif/imu_attitude_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_attitude_checker
// Watches the register port and both channels of the complementary angle
// filter. Keeps its own roll/pitch/yaw state and register copies, predicts
// the angles for every accepted sample and compares each result transaction
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module imu_attitude_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [icf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [15:0]             in_rate_x,
  input  logic signed [15:0]             in_rate_y,
  input  logic signed [15:0]             in_rate_z,
  input  logic signed [15:0]             in_accel_x,
  input  logic signed [15:0]             in_accel_y,
  input  logic signed [15:0]             in_accel_z,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [31:0]             out_roll_angle,
  input  logic signed [31:0]             out_pitch_angle,
  input  logic signed [31:0]             out_yaw_angle,
  input  logic                           out_accel_used,
  output int                             mismatch_total,
  output int                             pending
);
  import icf_pkg::*;

  localparam int STEPS    = 16;
  localparam int FRAC     = 16;
  localparam int ARC_FRAC = 24;
  localparam int PRESCALE = 14;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic               used;
  } attitude_t;

  attitude_t          attitude_q[$];
  logic [15:0]        gain;
  logic [16:0]        weight;
  logic [16:0]        mag_lo;
  logic [16:0]        mag_hi;
  logic signed [31:0] roll_acc;
  logic signed [31:0] pitch_acc;
  logic signed [31:0] yaw_acc;

  initial begin
    mismatch_total = 0;
    pending = 0;
  end

  // arctan(2^-i) in 2^-24 degree
  function automatic longint arc_of(input int i);
    case (i)
      0:       return 754974720;
      1:       return 445687602;
      2:       return 235489088;
      3:       return 119537938;
      4:       return 60000934;
      5:       return 30029717;
      6:       return 15018523;
      7:       return 7509720;
      8:       return 3754917;
      9:       return 1877466;
      10:      return 938734;
      11:      return 469367;
      12:      return 234684;
      13:      return 117342;
      14:      return 58671;
      15:      return 29335;
      16:      return 14668;
      17:      return 7334;
      18:      return 3667;
      19:      return 1833;
      20:      return 917;
      21:      return 458;
      22:      return 229;
      23:      return 115;
      default: return 0;
    endcase
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // vectoring CORDIC, angle of (den, num) in 2^-FRAC degree
  function automatic longint tilt(input longint num, input longint den);
    longint x, y, z, t, dx, dy;
    if (num == 0 && den == 0) return 0;
    x = den <<< PRESCALE;
    y = num <<< PRESCALE;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = longint'(90) <<< ARC_FRAC;
      end else begin
        x = -y;
        y = t;
        z = -(longint'(90) <<< ARC_FRAC);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + arc_of(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - arc_of(i);
      end
    end
    return (z + (longint'(1) <<< (ARC_FRAC - FRAC - 1))) >>> (ARC_FRAC - FRAC);
  endfunction

  function automatic longint mix(input longint angle, input longint target, input longint w);
    longint s;
    s = angle * w + target * (64'sd65536 - w) + 64'sd32768;
    return clamp32(s >>> 16);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_total < PRINT_CAP)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_total++;
  endtask

  always @(posedge clk) begin
    longint    gx, gy, gz, ax, ay, az, g, mag_sum, w;
    attitude_t want;
    if (!rst_n) begin
      gain      = GYRO_GAIN_RST;
      weight    = BLEND_WEIGHT_RST;
      mag_lo    = MAGNITUDE_LOW_RST;
      mag_hi    = MAGNITUDE_HIGH_RST;
      roll_acc  = '0;
      pitch_acc = '0;
      yaw_acc   = '0;
      attitude_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (attitude_q.size() == 0) begin
          report_mismatch("result transaction with no sample pending, roll",
                          out_roll_angle, 0);
        end else begin
          want = attitude_q.pop_front();
          if (out_roll_angle !== want.roll)
            report_mismatch("roll_angle", out_roll_angle, want.roll);
          if (out_pitch_angle !== want.pitch)
            report_mismatch("pitch_angle", out_pitch_angle, want.pitch);
          if (out_yaw_angle !== want.yaw)
            report_mismatch("yaw_angle", out_yaw_angle, want.yaw);
          if (out_accel_used !== want.used)
            report_mismatch("accel_used", longint'(out_accel_used), longint'(want.used));
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_GYRO_GAIN:      gain   = cfg_data[15:0];
          REG_BLEND_WEIGHT:   weight = cfg_data;
          REG_MAGNITUDE_LOW:  mag_lo = cfg_data;
          REG_MAGNITUDE_HIGH: mag_hi = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        gx = in_rate_x;
        gy = in_rate_y;
        gz = in_rate_z;
        ax = in_accel_x;
        ay = in_accel_y;
        az = in_accel_z;
        g  = longint'(gain);
        pitch_acc = 32'(clamp32(longint'(pitch_acc) + ((gx * g) >>> 8)));
        roll_acc  = 32'(clamp32(longint'(roll_acc) - ((gy * g) >>> 8)));
        yaw_acc   = 32'(clamp32(longint'(yaw_acc) - ((gz * g) >>> 8)));
        mag_sum = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
        want.used = (mag_sum > longint'(mag_lo)) && (mag_sum < longint'(mag_hi));
        if (want.used) begin
          w = (weight > WEIGHT_ONE) ? 64'sd65536 : longint'(weight);
          pitch_acc = 32'(mix(longint'(pitch_acc), tilt(ay, az), w));
          roll_acc  = 32'(mix(longint'(roll_acc), tilt(ax, az), w));
        end
        want.roll  = roll_acc;
        want.pitch = pitch_acc;
        want.yaw   = yaw_acc;
        attitude_q.push_back(want);
      end
    end
    pending = attitude_q.size();
  end

endmodule

// ----- verif/imu_complementary_filter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_complementary_filter_test
// Drives the complementary angle filter with directed corner samples, then
// random sample streams under several register settings (pure accel, pure
// gyro drift into saturation, clamped weight, random mixes), with random
// idling on both channels, a long output hold-off and a full drain pause.
// Checking is done by imu_attitude_checker.
// ----------------------------------------------------------------------------
module imu_complementary_filter_test;
  import icf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic signed [15:0]    in_rate_x;
  logic signed [15:0]    in_rate_y;
  logic signed [15:0]    in_rate_z;
  logic signed [15:0]    in_accel_x;
  logic signed [15:0]    in_accel_y;
  logic signed [15:0]    in_accel_z;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [31:0]    out_roll_angle;
  logic signed [31:0]    out_pitch_angle;
  logic signed [31:0]    out_yaw_angle;
  logic                  out_accel_used;

  int mismatch_total;
  int pending;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit hold_out = 1'b0;

  imu_complementary_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rate_x      (in_rate_x),
    .in_rate_y      (in_rate_y),
    .in_rate_z      (in_rate_z),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_roll_angle (out_roll_angle),
    .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle  (out_yaw_angle),
    .out_accel_used (out_accel_used)
  );

  imu_attitude_checker attitude_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rate_x      (in_rate_x),
    .in_rate_y      (in_rate_y),
    .in_rate_z      (in_rate_z),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_roll_angle (out_roll_angle),
    .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle  (out_yaw_angle),
    .out_accel_used (out_accel_used),
    .mismatch_total (mismatch_total),
    .pending        (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= !steady && ($urandom_range(99) < 17);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input int rx, input int ry, input int rz,
                             input int ax, input int ay, input int az);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rate_x  <= 16'(rx);
    in_rate_y  <= 16'(ry);
    in_rate_z  <= 16'(rz);
    in_accel_x <= 16'(ax);
    in_accel_y <= 16'(ay);
    in_accel_z <= 16'(az);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [15:0] gain, input logic [16:0] weight,
                               input logic [16:0] lo, input logic [16:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GYRO_GAIN;
    cfg_data  <= 17'(gain);
    @(negedge clk);
    cfg_index <= REG_BLEND_WEIGHT;
    cfg_data  <= weight;
    @(negedge clk);
    cfg_index <= REG_MAGNITUDE_LOW;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= REG_MAGNITUDE_HIGH;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // mostly values around zero, sometimes full range, extremes or zero
  function automatic int pick_field(input int span);
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 32767 : -32768;
      1, 2:    return int'($urandom_range(65535)) - 32768;
      3:       return 0;
      default: return int'($urandom_range(2 * span)) - span;
    endcase
  endfunction

  task automatic send_random;
    send_sample(pick_field(3000), pick_field(3000), pick_field(3000),
                pick_field(12000), pick_field(12000), pick_field(12000));
  endtask

  initial begin
    int n;
    int r;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_rate_x  = '0;
    in_rate_y  = '0;
    in_rate_z  = '0;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner samples at reset settings
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(32767, 32767, 32767, 0, 0, 16384);
    send_sample(-32768, -32768, -32768, 0, 0, -16384);
    send_sample(0, 0, 0, 8192, 0, 0);
    send_sample(0, 0, 0, 8193, 0, 0);
    send_sample(1, 1, 1, -8000, -9000, 0);
    send_sample(-1, -1, -1, 0, 0, 32767);
    send_sample(0, 0, 0, 16384, 16384, 0);
    send_sample(100, -100, 50, -10000, -10000, -10000);
    send_sample(-100, 100, -50, 10000, 10000, -10000);
    send_sample(0, 0, 0, -32768, -32768, -32768);
    send_sample(0, 0, 0, 32767, 32767, 32767);
    send_sample(0, 0, 0, 1, -1, -1);
    send_sample(-1, -1, -1, 5000, -5000, 5000);
    send_sample(1, 1, 1, 0, -12000, -12000);
    send_sample(0, 0, 0, 0, 12000, 0);
    send_sample(0, 0, 0, 0, -12000, 0);
    send_sample(-21845, 21845, -21846, -12000, 0, 12000);
    settle();

    // accel only, no gyro
    load_settings(16'd0, 17'd0, 17'd0, 17'd98304);
    for (n = 0; n < 30; n++) send_random();
    settle();

    // pure gyro at full gain, thresholds crossed: drift into saturation
    load_settings(16'd65535, 17'd65536, 17'd98304, 17'd0);
    for (n = 0; n < 290; n++) begin
      steady = (n < 120);
      r = 31000 + int'($urandom_range(1767));
      send_sample(r, 31000 + int'($urandom_range(1767)), -r,
                  pick_field(12000), pick_field(12000), pick_field(12000));
    end
    steady = 1'b0;
    settle();

    // weight above one, random gain; one full drain midway
    load_settings(16'($urandom), 17'd131071, 17'd100, 17'd60000);
    for (n = 0; n < 25; n++) begin
      if (n == 12) settle();
      send_random();
    end
    settle();

    // random mix with a long result hold-off
    load_settings(16'($urandom_range(2000)), 17'($urandom_range(65536)),
                  17'($urandom_range(8192)), 17'($urandom_range(98304, 20000)));
    for (n = 0; n < 70; n++) begin
      if (n == 20) hold_out = 1'b1;
      send_random();
    end
    settle();

    load_settings(16'd1, 17'd65535, 17'd0, 17'd98304);
    for (n = 0; n < 35; n++) send_random();
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_total == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
